FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the frame acknowledge handler.
// Depends on nothing; each macro samples on clk_i and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FBAH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define FBAH_ASSERT_NEVER(label, expr, msg) \
  `FBAH_ASSERT(label, !(expr), msg)

`endif

FILE: hw/rtl/fbah_pkg.sv
// Shared types and constants of the five-byte frame acknowledge handler.
// Depends on nothing; used by the front, queue, back and top-level files.
package fbah_pkg;

  // Result kinds carried on tuser.
  localparam logic [1:0] KIND_TX       = 2'd0;
  localparam logic [1:0] KIND_BILL     = 2'd1;
  localparam logic [1:0] KIND_CSUM_ERR = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  // Characters used in received commands and sent frames.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_UP_E   = 8'h45;
  localparam logic [7:0] CHAR_UP_S   = 8'h53;
  localparam logic [7:0] CHAR_UP_G   = 8'h47;
  localparam logic [7:0] CHAR_UP_B   = 8'h42;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;
  localparam logic [7:0] CHAR_LO_E   = 8'h65;
  localparam logic [7:0] CHAR_LO_S   = 8'h73;
  localparam logic [7:0] CHAR_LO_G   = 8'h67;
  localparam logic [7:0] CHAR_LO_B   = 8'h62;

  // Checksum of the constant request frame body.
  localparam logic [7:0] REQ_SUM = 8'(CHAR_UP_G + CHAR_UP_B + CHAR_QMARK);

  // Width of the result slot counter (up to ten results per frame).
  localparam int unsigned SLOT_W = 4;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // What the back end has to do for one completed frame.
  typedef enum logic [2:0] {
    OP_CSUM_ERR,
    OP_EVENT,
    OP_EVENT_REQ,
    OP_BILL,
    OP_UNKNOWN
  } op_e;

  // One classified frame as it travels through the queue.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] ack_sum;
  } frame_cmd_t;

endpackage

FILE: hw/rtl/fbah_front.sv
// Front end: counts byte positions, gathers command, data and sum,
// and classifies each finished frame. Depends on fbah_pkg.
module fbah_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic [7:0]           stack_end_code_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output fbah_pkg::frame_cmd_t push_cmd_o
);

  // Position of the next byte within the frame.
  localparam logic [2:0] POS_START = 3'd0;
  localparam logic [2:0] POS_CMD0  = 3'd1;
  localparam logic [2:0] POS_CMD1  = 3'd2;
  localparam logic [2:0] POS_DATA  = 3'd3;
  localparam logic [2:0] POS_CSUM  = 3'd4;

  // Sum of the two constant acknowledge characters.
  localparam logic [7:0] CHAR_LO_E_SUM = 8'(fbah_pkg::CHAR_LO_E + fbah_pkg::CHAR_LO_S);

  logic [2:0] pos_q, pos_d;
  logic [7:0] cmd0_q, cmd0_d;
  logic [7:0] cmd1_q, cmd1_d;
  logic [7:0] data_q, data_d;
  logic [7:0] sum_q, sum_d;
  logic       at_csum;
  logic       accept;

  // Positions above the data byte are all treated as the checksum byte.
  assign at_csum      = (pos_q >= POS_CSUM);
  assign in_ready_o   = at_csum ? push_ready_i : 1'b1;
  assign push_valid_o = in_valid_i && at_csum;
  assign accept       = in_valid_i && in_ready_o;

  // Classify the frame once the checksum byte is present.
  always_comb begin
    push_cmd_o.data    = data_q;
    push_cmd_o.ack_sum = 8'(CHAR_LO_E_SUM + data_q);
    if (sum_q != in_byte_i) begin
      push_cmd_o.op = fbah_pkg::OP_CSUM_ERR;
    end else if (cmd0_q == fbah_pkg::CHAR_UP_E && cmd1_q == fbah_pkg::CHAR_UP_S) begin
      push_cmd_o.op = (data_q == stack_end_code_i) ? fbah_pkg::OP_EVENT_REQ
                                                   : fbah_pkg::OP_EVENT;
    end else if (cmd0_q == fbah_pkg::CHAR_LO_G && cmd1_q == fbah_pkg::CHAR_LO_B) begin
      push_cmd_o.op = fbah_pkg::OP_BILL;
    end else begin
      push_cmd_o.op = fbah_pkg::OP_UNKNOWN;
    end
  end

  // Position sequencer and field capture.
  always_comb begin
    pos_d  = pos_q;
    cmd0_d = cmd0_q;
    cmd1_d = cmd1_q;
    data_d = data_q;
    sum_d  = sum_q;
    if (accept) begin
      unique case (pos_q)
        POS_START: begin
          pos_d = POS_CMD0;
        end
        POS_CMD0: begin
          cmd0_d = in_byte_i;
          sum_d  = in_byte_i;
          pos_d  = POS_CMD1;
        end
        POS_CMD1: begin
          cmd1_d = in_byte_i;
          sum_d  = sum_q + in_byte_i;
          pos_d  = POS_DATA;
        end
        POS_DATA: begin
          data_d = in_byte_i;
          sum_d  = sum_q + in_byte_i;
          pos_d  = POS_CSUM;
        end
        default: begin
          pos_d = POS_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_START;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd0_q <= cmd0_d;
    cmd1_q <= cmd1_d;
    data_q <= data_d;
    sum_q  <= sum_d;
  end

endmodule

FILE: hw/rtl/fbah_queue.sv
// Short queue of classified frames between the front and back ends.
// Depends on fbah_pkg for the entry type.
module fbah_queue #(
  parameter int unsigned Depth = fbah_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  fbah_pkg::frame_cmd_t push_cmd_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output fbah_pkg::frame_cmd_t pop_cmd_o,
  output logic                 full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  fbah_pkg::frame_cmd_t entries_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o       = (count_q == FullCnt);
  assign push_ready_o = !full_o;
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: hw/rtl/fbah_back.sv
// Back end: turns each queued frame command into its result items and
// holds them in an output register. Depends on fbah_pkg.
module fbah_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  fbah_pkg::frame_cmd_t cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_kind_o,
  output logic [7:0]           out_value_o,
  output logic                 out_last_o
);

  localparam int unsigned SlotW = fbah_pkg::SLOT_W;

  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] last_slot;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       value_q, value_d;
  logic             last_q, last_d;
  logic             advance;
  logic             slot_last;

  // A new item is produced whenever a command waits and the output register is free or drains.
  assign advance     = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign slot_last   = (slot_q == last_slot);
  assign cmd_ready_o = advance && slot_last;

  // Number of the final result slot for each command.
  always_comb begin
    unique case (cmd_i.op)
      fbah_pkg::OP_EVENT:     last_slot = SlotW'(4);
      fbah_pkg::OP_EVENT_REQ: last_slot = SlotW'(9);
      default:                last_slot = '0;
    endcase
  end

  // Result item for the current slot.
  always_comb begin
    kind_d  = fbah_pkg::KIND_TX;
    value_d = '0;
    unique case (cmd_i.op) inside
      fbah_pkg::OP_CSUM_ERR: kind_d = fbah_pkg::KIND_CSUM_ERR;
      fbah_pkg::OP_BILL: begin
        kind_d  = fbah_pkg::KIND_BILL;
        value_d = cmd_i.data;
      end
      fbah_pkg::OP_EVENT, fbah_pkg::OP_EVENT_REQ: begin
        case (slot_q)
          SlotW'(0): value_d = fbah_pkg::CHAR_DOLLAR;
          SlotW'(1): value_d = fbah_pkg::CHAR_LO_E;
          SlotW'(2): value_d = fbah_pkg::CHAR_LO_S;
          SlotW'(3): value_d = cmd_i.data;
          SlotW'(4): value_d = cmd_i.ack_sum;
          SlotW'(5): value_d = fbah_pkg::CHAR_DOLLAR;
          SlotW'(6): value_d = fbah_pkg::CHAR_UP_G;
          SlotW'(7): value_d = fbah_pkg::CHAR_UP_B;
          SlotW'(8): value_d = fbah_pkg::CHAR_QMARK;
          default:   value_d = fbah_pkg::REQ_SUM;
        endcase
      end
      default: kind_d = fbah_pkg::KIND_UNKNOWN;
    endcase
    last_d = slot_last;
  end

  // Slot counter steps through the results of the head command.
  always_comb begin
    slot_d = slot_q;
    if (advance) begin
      slot_d = slot_last ? '0 : slot_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = value_q;
  assign out_last_o  = last_q;

endmodule

FILE: hw/rtl/five_byte_frame_ack_handler.sv
// Five-byte frame acknowledge handler, top level. Depends on fbah_pkg,
// fbah_front, fbah_queue, fbah_back and assert_macros.svh.
// A frame's first result item passes the queue register, then the output register.
// Throughput: one input byte per cycle, held off only at a checksum byte while the queue
// is full; one result item per cycle unless the output stalls; 5 or 10 per event frame.
// Reset clears the byte position, the queue, the sequencer and the stack end code to zero.
`include "assert_macros.svh"

module five_byte_frame_ack_handler #(
  parameter int unsigned QueueDepth = fbah_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: stack end code.
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // Received bytes.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  // Result items.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] value
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last result caused by one byte
);

  logic [7:0]           stack_end_code_q;
  logic                 push_valid;
  logic                 push_ready;
  fbah_pkg::frame_cmd_t push_cmd;
  logic                 pop_valid;
  logic                 pop_ready;
  fbah_pkg::frame_cmd_t pop_cmd;
  logic                 queue_full;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_end_code_q <= '0;
    end else if (cfg_we_i) begin
      stack_end_code_q <= cfg_wdata_i;
    end
  end

  fbah_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_byte_i       (s_axis_tdata),
    .stack_end_code_i(stack_end_code_q),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  fbah_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd),
    .full_o      (queue_full)
  );

  fbah_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(pop_valid),
    .cmd_ready_o(pop_ready),
    .cmd_i      (pop_cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (m_axis_tuser),
    .out_value_o(m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

  // The front only holds off input when the queue has no room.
  `FBAH_ASSERT(a_stall_only_when_full, !s_axis_tready |-> queue_full,
    "input stalled with queue space")

  // A checksum byte is never offered to a full queue as accepted.
  `FBAH_ASSERT_NEVER(a_no_push_when_full, push_valid && push_ready && queue_full,
    "push into full queue")

  // Single-item results always close their byte's result group.
  `FBAH_ASSERT(a_single_items_last,
    m_axis_tvalid && (m_axis_tuser == fbah_pkg::KIND_BILL ||
    m_axis_tuser == fbah_pkg::KIND_CSUM_ERR || m_axis_tuser == fbah_pkg::KIND_UNKNOWN)
    |-> m_axis_tlast,
    "single result without last")

endmodule

FILE: tb/five_byte_frame_ack_handler_tb.sv
// Testbench of five_byte_frame_ack_handler: drives received bytes as frames and noise,
// predicts the acknowledge, request, bill and error items and checks every one of them.
// Depends on fbah_pkg and the five_byte_frame_ack_handler RTL.
`timescale 1ns / 100ps

module five_byte_frame_ack_handler_tb;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleDelay = 8;
  localparam int unsigned MaxReported = 10;

  // One result item as seen on the master side.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } ack_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  // Predictor state: a private copy of the frame decoder.
  logic [2:0] rx_pos;
  logic [7:0] rx_cmd_first;
  logic [7:0] rx_cmd_second;
  logic [7:0] rx_data;
  logic [7:0] rx_sum;
  logic [7:0] stack_end_code;

  ack_item_t  ack_items_due[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  five_byte_frame_ack_handler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue the five items of one outgoing frame: '$', three body bytes, their sum.
  task automatic queue_tx_frame(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2);
    logic [7:0] body_sum;
    body_sum = c0 + c1 + c2;
    ack_items_due.push_back('{fbah_pkg::KIND_TX, fbah_pkg::CHAR_DOLLAR, 1'b0});
    ack_items_due.push_back('{fbah_pkg::KIND_TX, c0, 1'b0});
    ack_items_due.push_back('{fbah_pkg::KIND_TX, c1, 1'b0});
    ack_items_due.push_back('{fbah_pkg::KIND_TX, c2, 1'b0});
    ack_items_due.push_back('{fbah_pkg::KIND_TX, body_sum, 1'b0});
  endtask

  // Advance the predictor by one accepted byte and queue the items it causes.
  task automatic decode_rx_byte(input logic [7:0] b);
    int unsigned before_cnt;
    before_cnt = ack_items_due.size();
    case (rx_pos)
      3'd0: rx_pos = 3'd1;
      3'd1: begin
        rx_cmd_first = b;
        rx_sum       = b;
        rx_pos       = 3'd2;
      end
      3'd2: begin
        rx_cmd_second = b;
        rx_sum        = rx_sum + b;
        rx_pos        = 3'd3;
      end
      3'd3: begin
        rx_data = b;
        rx_sum  = rx_sum + b;
        rx_pos  = 3'd4;
      end
      default: begin
        rx_pos = 3'd0;
        if (rx_sum != b) begin
          ack_items_due.push_back('{fbah_pkg::KIND_CSUM_ERR, 8'h00, 1'b0});
        end else if (rx_cmd_first == fbah_pkg::CHAR_UP_E &&
                     rx_cmd_second == fbah_pkg::CHAR_UP_S) begin
          queue_tx_frame(fbah_pkg::CHAR_LO_E, fbah_pkg::CHAR_LO_S, rx_data);
          if (rx_data == stack_end_code) begin
            queue_tx_frame(fbah_pkg::CHAR_UP_G, fbah_pkg::CHAR_UP_B, fbah_pkg::CHAR_QMARK);
          end
        end else if (rx_cmd_first == fbah_pkg::CHAR_LO_G &&
                     rx_cmd_second == fbah_pkg::CHAR_LO_B) begin
          ack_items_due.push_back('{fbah_pkg::KIND_BILL, rx_data, 1'b0});
        end else begin
          ack_items_due.push_back('{fbah_pkg::KIND_UNKNOWN, 8'h00, 1'b0});
        end
        // The checksum byte always causes at least one item; flag the final one.
        if (ack_items_due.size() > before_cnt) begin
          ack_items_due[ack_items_due.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  // Offer one byte on the slave side, with random idle cycles first, and wait
  // for the handshake. The valid stays high afterwards for the next byte.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_rx_byte(b);
  endtask

  // Send a whole frame; a nonzero csum_offset corrupts the checksum byte.
  task automatic send_frame(input logic [7:0] start_b, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] data_b,
                            input logic [7:0] csum_offset);
    send_byte(start_b);
    send_byte(c1);
    send_byte(c2);
    send_byte(data_b);
    send_byte(c1 + c2 + data_b + csum_offset);
  endtask

  // Close any open frame, stop sending and let every expected item arrive,
  // then give the block time to settle.
  task automatic drain_block;
    while (rx_pos != 3'd0) begin
      send_byte(8'($urandom));
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (ack_items_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  // Write the stack end code while the block is idle.
  task automatic write_stack_end(input logic [7:0] code);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    stack_end_code = code;
  endtask

  // Random traffic: mostly well-formed frames with random content, plus
  // near-miss commands, corrupted checksums and stray bytes that shift framing.
  task automatic run_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  data_b;
    sent = 0;
    while (sent < n_items) begin
      pick   = $urandom_range(99);
      data_b = ($urandom_range(1) == 1) ? stack_end_code : 8'($urandom);
      if (pick < 35) begin
        send_frame(8'($urandom), fbah_pkg::CHAR_UP_E, fbah_pkg::CHAR_UP_S, data_b, 8'h00);
      end else if (pick < 55) begin
        send_frame(8'($urandom), fbah_pkg::CHAR_LO_G, fbah_pkg::CHAR_LO_B, 8'($urandom),
                   8'h00);
      end else if (pick < 65) begin
        // Commands one letter off from a known one.
        case ($urandom_range(3))
          0: send_frame(fbah_pkg::CHAR_DOLLAR, fbah_pkg::CHAR_LO_E, fbah_pkg::CHAR_UP_S,
                        data_b, 8'h00);
          1: send_frame(fbah_pkg::CHAR_DOLLAR, fbah_pkg::CHAR_UP_E, fbah_pkg::CHAR_LO_S,
                        data_b, 8'h00);
          2: send_frame(fbah_pkg::CHAR_DOLLAR, fbah_pkg::CHAR_UP_G, fbah_pkg::CHAR_LO_B,
                        data_b, 8'h00);
          default: send_frame(fbah_pkg::CHAR_DOLLAR, fbah_pkg::CHAR_LO_G,
                              fbah_pkg::CHAR_UP_B, data_b, 8'h00);
        endcase
      end else if (pick < 75) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'h00);
      end else if (pick < 88) begin
        send_frame(8'($urandom),
                   ($urandom_range(1) == 1) ? fbah_pkg::CHAR_UP_E : fbah_pkg::CHAR_LO_G,
                   ($urandom_range(1) == 1) ? fbah_pkg::CHAR_UP_S : fbah_pkg::CHAR_LO_B,
                   data_b, 8'($urandom_range(255, 1)));
      end
      if (pick >= 75 && pick < 88) begin
        sent += 5;
      end else if (pick >= 88) begin
        // A stray byte knocks the framing off by one.
        send_byte(8'($urandom));
        sent += 1;
      end else begin
        sent += 5;
      end
    end
  endtask

  // Directed frames: each command, a bad checksum and the byte extremes.
  task automatic test_directed_frames;
    send_frame(8'h00, fbah_pkg::CHAR_UP_E, fbah_pkg::CHAR_UP_S, 8'h00, 8'h00);
    send_frame(8'hFF, fbah_pkg::CHAR_UP_E, fbah_pkg::CHAR_UP_S, 8'hFF, 8'h00);
    send_frame(fbah_pkg::CHAR_DOLLAR, fbah_pkg::CHAR_LO_G, fbah_pkg::CHAR_LO_B, 8'hFF, 8'h00);
    send_frame(fbah_pkg::CHAR_DOLLAR, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'hFF, fbah_pkg::CHAR_UP_E, fbah_pkg::CHAR_UP_S, 8'hFF, 8'hFF);
    drain_block();
  endtask

  // Full-rate traffic, with the highest stack end code.
  task automatic test_no_idling;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_stack_end(8'hFF);
    run_random_frames(115);
    drain_block();
  endtask

  // A mostly idle sender.
  task automatic test_sender_idle;
    sender_idle_pct    = 74;
    receiver_stall_pct = 0;
    write_stack_end(8'($urandom));
    run_random_frames(115);
    drain_block();
  endtask

  // A receiver that stalls most of the time, so the request frame backs up.
  task automatic test_receiver_stall;
    sender_idle_pct    = 0;
    receiver_stall_pct = 74;
    write_stack_end(8'h00);
    run_random_frames(115);
    drain_block();
  endtask

  // Light idling on both sides.
  task automatic test_both_idle;
    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    write_stack_end(fbah_pkg::CHAR_LO_S);
    run_random_frames(115);
    drain_block();
  endtask

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare every accepted result item with the oldest expected one.
  always @(posedge clk_i) begin
    ack_item_t exp_item;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ack_items_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("%0t: unexpected item kind=%0d value=%02h last=%0b", $realtime,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end else begin
        exp_item = ack_items_due.pop_front();
        if (m_axis_tuser !== exp_item.kind || m_axis_tdata !== exp_item.value ||
            m_axis_tlast !== exp_item.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("%0t: expected kind=%0d value=%02h last=%0b, got %0d %02h %0b",
                     $realtime, exp_item.kind, exp_item.value, exp_item.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 8'h00;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = 8'h00;
    m_axis_tready      = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    quiet_cycles       = 0;
    rx_pos             = 3'd0;
    rx_cmd_first       = 8'h00;
    rx_cmd_second      = 8'h00;
    rx_data            = 8'h00;
    rx_sum             = 8'h00;
    stack_end_code     = 8'h00;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_frames();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    if (mismatch_count == 0 && ack_items_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
